@@ design/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// shared types, sizes and constants of the bitmap block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int unsigned BLOCK_TOTAL     = 512;
  localparam int unsigned WORDS_PER_BLOCK = 4;
  localparam int unsigned MAP_ROW_W       = 64;
  localparam int unsigned MAP_ROWS        = BLOCK_TOTAL / MAP_ROW_W;
  localparam int unsigned ROW_AW          = $clog2(MAP_ROWS);
  localparam int unsigned POS_W           = $clog2(MAP_ROW_W);
  localparam int unsigned BLK_W           = 9;
  localparam int unsigned WIDX_W          = 2;
  localparam int unsigned WORD_W          = 64;
  localparam int unsigned CNT_W           = 10;
  localparam int unsigned WADDR_W         = BLK_W + WIDX_W;
  localparam int unsigned WORD_DEPTH      = BLOCK_TOTAL * WORDS_PER_BLOCK;
  localparam int unsigned MAP_BLOCK_A     = 127;
  localparam int unsigned MAP_BLOCK_B     = 128;
  localparam int unsigned INIT_USED       = 2;

  typedef enum logic [2:0] {
    OP_ALLOC   = 3'd0,
    OP_REQUEST = 3'd1,
    OP_RELEASE = 3'd2,
    OP_READ    = 3'd3,
    OP_WRITE   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC_CHK,
    ST_BIT_CHK,
    ST_WORD_RD,
    ST_RESP
  } state_e;

  // map row port request
  typedef struct packed {
    logic                 rd;
    logic                 wr;
    logic [ROW_AW-1:0]    addr;
    logic [MAP_ROW_W-1:0] wdata;
  } map_req_t;

  // map row contents after reset: only the two reserved blocks are set
  function automatic logic [MAP_ROW_W-1:0] map_reset_row(input logic [ROW_AW-1:0] row);
    logic [MAP_ROW_W-1:0] r;
    logic [BLK_W-1:0]     idx;
    r = '0;
    for (int i = 0; i < MAP_ROW_W; i++) begin
      idx  = {row, POS_W'(i)};
      r[i] = (idx == BLK_W'(MAP_BLOCK_A)) || (idx == BLK_W'(MAP_BLOCK_B));
    end
    return r;
  endfunction

endpackage

@@ design/bba_map_store.sv @@
// ----------------------------------------------------------------------------
// bba_map_store
// used-block map held as rows of 64 bits, one registered read port and one
// write port; a row never written reads as its reset pattern
// ----------------------------------------------------------------------------
module bba_map_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bba_pkg::map_req_t             req_i,
  output logic [bba_pkg::MAP_ROW_W-1:0] rdata_o
);
  import bba_pkg::*;

  logic [MAP_ROW_W-1:0] mem_q [MAP_ROWS];
  logic [MAP_ROWS-1:0]  row_valid_q;
  logic [MAP_ROW_W-1:0] rdata_q;
  logic                 rvalid_q;
  logic [ROW_AW-1:0]    raddr_q;

  // row valid bits and read side flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rvalid_q    <= 1'b0;
      raddr_q     <= '0;
    end else begin
      if (req_i.rd) begin
        rvalid_q <= row_valid_q[req_i.addr];
        raddr_q  <= req_i.addr;
      end
      if (req_i.wr) begin
        row_valid_q[req_i.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd) begin
      rdata_q <= mem_q[req_i.addr];
    end
    if (req_i.wr) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : map_reset_row(raddr_q);

endmodule

@@ design/bitmap_block_allocator_core.sv @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// block store with a used-block bitmap: allocate, request, release, read and
// write of one 64-bit word, each answered by one result transfer
//
// usage
//   input channel: in_valid_i / in_stall_o with op, target_blk, word_index and
//   write_data; output channel: out_valid_o / out_stall_i with status,
//   block_index, read_data, used_count and free_count
//   one item is in work at a time; in_stall_o stays high until its result
//   has been placed in the output register
//   allocate scans the 64-bit map rows in order, up to 8 rows, and claims the
//   lowest free block found; request and release check one map bit, read
//   fetches one stored word, write and unknown ops go straight to the result
//   the map row scan uses a find-first-free unit on each row it reads
//   reset: the map reads as all free except blocks 127 and 128, used count 2;
//   block words hold nothing until written
//   a stalled result holds in the output register; the next item may still
//   be taken, and its result waits until the register frees
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  op_i,
  input  logic [bba_pkg::BLK_W-1:0]   target_blk_i,
  input  logic [bba_pkg::WIDX_W-1:0]  word_index_i,
  input  logic [bba_pkg::WORD_W-1:0]  write_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        status_o,
  output logic [bba_pkg::BLK_W-1:0]   block_index_o,
  output logic [bba_pkg::WORD_W-1:0]  read_data_o,
  output logic [bba_pkg::CNT_W-1:0]   used_count_o,
  output logic [bba_pkg::CNT_W-1:0]   free_count_o
);
  import bba_pkg::*;

  // find the lowest clear bit of a map row
  function automatic logic [POS_W:0] find_free(input logic [MAP_ROW_W-1:0] v);
    logic [POS_W-1:0] pos;
    logic             found;
    pos   = '0;
    found = 1'b0;
    for (int i = MAP_ROW_W - 1; i >= 0; i--) begin
      if (!v[i]) begin
        found = 1'b1;
        pos   = POS_W'(i);
      end
    end
    return {found, pos};
  endfunction

  state_e               state_q, state_d;
  logic [2:0]           op_q;
  logic [BLK_W-1:0]     bid_q;
  logic                 word_ok_q;
  logic [ROW_AW-1:0]    row_q, row_d;
  logic [CNT_W-1:0]     used_q, used_d;

  // result held between the working states and the output register
  logic                 res_status_q, res_status_d;
  logic [BLK_W-1:0]     res_index_q, res_index_d;
  logic [WORD_W-1:0]    res_data_q, res_data_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_status_q;
  logic [BLK_W-1:0]     out_index_q;
  logic [WORD_W-1:0]    out_data_q;
  logic [CNT_W-1:0]     out_used_q, out_free_q;
  logic                 out_load;

  map_req_t             map_req;
  logic [MAP_ROW_W-1:0] map_rdata;

  logic [WORD_W-1:0]    word_mem_q [WORD_DEPTH];
  logic [WORD_W-1:0]    word_rd_q;
  logic                 word_rd, word_wr;
  logic [WADDR_W-1:0]   word_addr;

  logic                 in_xfer;
  logic                 in_range, word_ok;
  logic [POS_W:0]       ffz;
  logic                 map_bit;
  logic [POS_W-1:0]     bid_pos;

  bba_map_store u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (map_req),
    .rdata_o (map_rdata)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign in_range   = ({1'b0, target_blk_i} < CNT_W'(BLOCK_TOTAL));
  assign word_ok    = in_range && ({1'b0, word_index_i} < (WIDX_W + 1)'(WORDS_PER_BLOCK));
  assign word_addr  = {target_blk_i, word_index_i};
  assign word_rd    = in_xfer && (op_i == OP_READ) && word_ok;
  assign word_wr    = in_xfer && (op_i == OP_WRITE) && word_ok;
  assign ffz        = find_free(map_rdata);
  assign bid_pos    = bid_q[POS_W-1:0];
  assign map_bit    = map_rdata[bid_pos];
  assign out_load   = (state_q == ST_RESP) && (!out_valid_q || !out_stall_i);

  // word store, written and read straight from the input transfer
  always_ff @(posedge clk_i) begin
    if (word_wr) begin
      word_mem_q[word_addr] <= write_data_i;
    end
    if (word_rd) begin
      word_rd_q <= word_mem_q[word_addr];
    end
  end

  // sequencer: issues map row reads, checks a row a cycle, writes back
  always_comb begin
    state_d      = state_q;
    row_d        = row_q;
    used_d       = used_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    res_data_d   = res_data_q;
    map_req      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          res_status_d = 1'b1;
          res_index_d  = target_blk_i;
          res_data_d   = '0;
          unique case (op_i)
            OP_ALLOC: begin
              row_d        = '0;
              map_req.rd   = 1'b1;
              map_req.addr = '0;
              state_d      = ST_ALLOC_CHK;
            end
            OP_REQUEST, OP_RELEASE: begin
              map_req.rd   = 1'b1;
              map_req.addr = target_blk_i[BLK_W-1:POS_W];
              state_d      = ST_BIT_CHK;
            end
            OP_READ: begin
              state_d = ST_WORD_RD;
            end
            OP_WRITE: begin
              res_status_d = !word_ok;
              state_d      = ST_RESP;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      ST_ALLOC_CHK: begin
        if (ffz[POS_W]) begin
          // free bit in this row: claim it
          map_req.wr    = 1'b1;
          map_req.addr  = row_q;
          map_req.wdata = map_rdata | (MAP_ROW_W'(1) << ffz[POS_W-1:0]);
          used_d        = used_q + CNT_W'(1);
          res_status_d  = 1'b0;
          res_index_d   = {row_q, ffz[POS_W-1:0]};
          state_d       = ST_RESP;
        end else if (row_q == ROW_AW'(MAP_ROWS - 1)) begin
          // store full
          res_status_d = 1'b1;
          res_index_d  = '0;
          state_d      = ST_RESP;
        end else begin
          row_d        = row_q + ROW_AW'(1);
          map_req.rd   = 1'b1;
          map_req.addr = row_q + ROW_AW'(1);
        end
      end

      ST_BIT_CHK: begin
        map_req.addr = bid_q[BLK_W-1:POS_W];
        if (op_q == OP_REQUEST) begin
          if (word_ok_q && (bid_q != '0) && !map_bit) begin
            map_req.wr    = 1'b1;
            map_req.wdata = map_rdata | (MAP_ROW_W'(1) << bid_pos);
            used_d        = used_q + CNT_W'(1);
            res_status_d  = 1'b0;
          end
        end else begin
          // release always succeeds; a free block is left alone
          res_status_d = 1'b0;
          if (word_ok_q && map_bit) begin
            map_req.wr    = 1'b1;
            map_req.wdata = map_rdata & ~(MAP_ROW_W'(1) << bid_pos);
            used_d        = used_q - CNT_W'(1);
          end
        end
        state_d = ST_RESP;
      end

      ST_WORD_RD: begin
        res_status_d = !word_ok_q;
        res_data_d   = word_ok_q ? word_rd_q : '0;
        state_d      = ST_RESP;
      end

      ST_RESP: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= CNT_W'(INIT_USED);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q      <= op_i;
      bid_q     <= target_blk_i;
      // read and write need the word check, request and release the range
      word_ok_q <= ((op_i == OP_READ) || (op_i == OP_WRITE)) ? word_ok : in_range;
    end
    row_q        <= row_d;
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    res_data_q   <= res_data_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_index_q  <= res_index_q;
      out_data_q   <= res_data_q;
      out_used_q   <= used_q;
      out_free_q   <= CNT_W'(BLOCK_TOTAL) - used_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign block_index_o = out_index_q;
  assign read_data_o   = out_data_q;
  assign used_count_o  = out_used_q;
  assign free_count_o  = out_free_q;

  // used and free counts always add up to the store size
  a_count_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (used_count_o + free_count_o == CNT_W'(BLOCK_TOTAL)))
    else $error("used and free counts do not add up");

  // the map is only written from a checking state
  a_map_wr_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_req.wr |-> (state_q == ST_ALLOC_CHK || state_q == ST_BIT_CHK))
    else $error("map write outside a checking state");

  // a held result is not overwritten while the receiver stalls
  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && out_valid_o && out_stall_i) |=> (state_q == ST_RESP))
    else $error("result left the response state during a stall");

  // used count never passes the store size
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(BLOCK_TOTAL))
    else $error("used count beyond store size");

endmodule

@@ bench/bitmap_block_allocator_core_tb.sv @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core_tb
// self-checking bench for the bitmap block allocator: every input transfer is
// run through a bit-exact predictor of the map, the used count and the block
// words, and every result transfer is compared field by field in order
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core_tb;
  import bba_pkg::*;

  // run bounds: the slowest item is a full eight-row allocate scan plus
  // random stalls on both sides; the cycle limit covers the whole run
  localparam int unsigned RUN_LIMIT  = 200_000;
  localparam int unsigned END_SETTLE = 24;
  localparam int unsigned IDLE_PCT   = 36;
  localparam int unsigned ITEM_GOAL  = 1124;

  // weighting of the random stimulus
  typedef enum int {
    MIX_BALANCED,
    MIX_FILL,
    MIX_DRAIN
  } mix_e;

  typedef struct packed {
    logic              status;
    logic [BLK_W-1:0]  block_index;
    logic [WORD_W-1:0] read_data;
    logic [CNT_W-1:0]  used_count;
    logic [CNT_W-1:0]  free_count;
  } alloc_result_t;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of the used map, the used count and the block words
  // --------------------------------------------------------------------------
  class alloc_scoreboard;
    bit                used_map [BLOCK_TOTAL];
    logic [WORD_W-1:0] block_words [WORD_DEPTH];
    int unsigned       used_total;
    alloc_result_t     pending_results [$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       granted;
    int unsigned       refused_full;
    int unsigned       reads_done;
    int unsigned       peak_used;

    function new();
      foreach (used_map[b]) used_map[b] = 1'b0;
      used_map[MAP_BLOCK_A] = 1'b1;
      used_map[MAP_BLOCK_B] = 1'b1;
      used_total = INIT_USED;
      peak_used  = INIT_USED;
    endfunction

    // work out the result of one accepted input transfer and queue it
    function void note_transfer(input logic [2:0]        op,
                                input logic [BLK_W-1:0]  bid,
                                input logic [WIDX_W-1:0] widx,
                                input logic [WORD_W-1:0] wdata);
      alloc_result_t res;
      int            waddr;
      res.status      = 1'b1;
      res.block_index = bid;
      res.read_data   = '0;
      waddr = int'(bid) * WORDS_PER_BLOCK + int'(widx);
      case (op)
        OP_ALLOC: begin
          res.block_index = '0;
          for (int b = 0; b < BLOCK_TOTAL; b++) begin
            if (!used_map[b]) begin
              used_map[b] = 1'b1;
              used_total++;
              res.block_index = BLK_W'(b);
              res.status      = 1'b0;
              granted++;
              break;
            end
          end
          if (res.status) refused_full++;
        end
        OP_REQUEST: begin
          if (bid != 0 && !used_map[bid]) begin
            used_map[bid] = 1'b1;
            used_total++;
            res.status = 1'b0;
          end
        end
        OP_RELEASE: begin
          if (used_map[bid]) begin
            used_map[bid] = 1'b0;
            used_total--;
          end
          res.status = 1'b0;
        end
        OP_READ: begin
          res.read_data = block_words[waddr];
          res.status    = 1'b0;
          reads_done++;
        end
        OP_WRITE: begin
          block_words[waddr] = wdata;
          res.status         = 1'b0;
        end
        default: ;
      endcase
      if (used_total > peak_used) peak_used = used_total;
      res.used_count = CNT_W'(used_total);
      res.free_count = CNT_W'(BLOCK_TOTAL - used_total);
      pending_results.push_back(res);
    endfunction

    task report(input string msg);
      $display("%0t  mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_field(input string name, input logic [WORD_W-1:0] got_v,
                     input logic [WORD_W-1:0] want_v);
      if (got_v !== want_v)
        report($sformatf("result %0d %s got %0h expected %0h", checked, name, got_v, want_v));
    endtask

    task check_result(input alloc_result_t got);
      alloc_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing pending, block_index %0d", got.block_index));
        return;
      end
      want = pending_results.pop_front();
      checked++;
      check_field("status", got.status, want.status);
      check_field("block_index", got.block_index, want.block_index);
      check_field("read_data", got.read_data, want.read_data);
      check_field("used_count", got.used_count, want.used_count);
      check_field("free_count", got.free_count, want.free_count);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // block ports, all inputs at known values from time zero
  // --------------------------------------------------------------------------
  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              in_stall_o;
  logic [2:0]        op_i         = '0;
  logic [BLK_W-1:0]  target_blk_i = '0;
  logic [WIDX_W-1:0] word_index_i = '0;
  logic [WORD_W-1:0] write_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i  = 1'b0;
  logic              status_o;
  logic [BLK_W-1:0]  block_index_o;
  logic [WORD_W-1:0] read_data_o;
  logic [CNT_W-1:0]  used_count_o;
  logic [CNT_W-1:0]  free_count_o;

  alloc_scoreboard alloc_sb = new();

  // stimulus bookkeeping: only words that have been written are ever read
  bit          word_written [WORD_DEPTH];
  int          written_list [$];
  int unsigned items_sent  = 0;
  int unsigned cycle_count = 0;
  bit          quiet       = 1'b0;   // no idling on either side while set

  bitmap_block_allocator_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .target_blk_i  (target_blk_i),
    .word_index_i  (word_index_i),
    .write_data_i  (write_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .block_index_o (block_index_o),
    .read_data_o   (read_data_o),
    .used_count_o  (used_count_o),
    .free_count_o  (free_count_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               alloc_sb.pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: values read at the edge are the ones from before it, so the
  // transfer check and the new stall decision never race with the block
  always @(posedge clk_i) begin : result_side
    alloc_result_t seen;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.status      = status_o;
      seen.block_index = block_index_o;
      seen.read_data   = read_data_o;
      seen.used_count  = used_count_o;
      seen.free_count  = free_count_o;
      alloc_sb.check_result(seen);
    end
    out_stall_i <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------

  // one input transfer: random idle cycles first, then hold the payload
  // until an edge sees valid high and stall low
  task automatic send_item(input logic [2:0] op, input logic [BLK_W-1:0] bid,
                           input logic [WIDX_W-1:0] widx, input logic [WORD_W-1:0] wdata);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    target_blk_i <= bid;
    word_index_i <= widx;
    write_data_i <= wdata;
    do @(posedge clk_i); while (in_stall_o);
    alloc_sb.note_transfer(op, bid, widx, wdata);
    items_sent++;
  endtask

  task automatic send_write(input int bid, input int widx, input logic [WORD_W-1:0] data);
    int addr;
    addr = bid * WORDS_PER_BLOCK + widx;
    if (!word_written[addr]) begin
      word_written[addr] = 1'b1;
      written_list.push_back(addr);
    end
    send_item(OP_WRITE, BLK_W'(bid), WIDX_W'(widx), data);
  endtask

  // sender holds off until every queued result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (alloc_sb.pending_results.size() != 0);
  endtask

  // a block in the wanted state, searched from a random start, or -1
  function automatic int find_block(input bit want_used);
    int start;
    int b;
    start = $urandom_range(0, BLOCK_TOTAL - 1);
    for (int n = 0; n < BLOCK_TOTAL; n++) begin
      b = (start + n) % BLOCK_TOTAL;
      if (alloc_sb.used_map[b] == want_used) return b;
    end
    return -1;
  endfunction

  task automatic random_item(input mix_e mix);
    int                w [6];   // allocate, request, release, read, write, unknown
    int                r;
    int                k;
    int                b;
    int                addr;
    logic [WORD_W-1:0] data;
    case (mix)
      MIX_FILL:  w = '{70, 12, 2, 6, 8, 2};
      MIX_DRAIN: w = '{8, 7, 60, 10, 12, 3};
      default:   w = '{20, 20, 20, 15, 20, 5};
    endcase
    r = $urandom_range(0, 99);
    k = 0;
    while (r >= w[k]) begin
      r -= w[k];
      k++;
    end
    data = {$urandom, $urandom};
    // a read with nothing written yet turns into a write
    if (k == int'(OP_READ) && written_list.size() == 0) k = int'(OP_WRITE);
    case (k)
      int'(OP_ALLOC): begin
        // the block field is ignored here, but random content still toggles the port
        send_item(OP_ALLOC, BLK_W'($urandom), WIDX_W'($urandom), data);
      end
      int'(OP_REQUEST), int'(OP_RELEASE): begin
        // mostly a block in the state that lets the operation take effect
        b = ($urandom_range(0, 99) < 60) ? find_block(k == int'(OP_RELEASE)) : -1;
        if (b < 0) b = $urandom_range(0, BLOCK_TOTAL - 1);
        send_item(3'(k), BLK_W'(b), WIDX_W'($urandom), data);
      end
      int'(OP_READ): begin
        addr = written_list[$urandom_range(0, written_list.size() - 1)];
        send_item(OP_READ, BLK_W'(addr / WORDS_PER_BLOCK), WIDX_W'(addr % WORDS_PER_BLOCK),
                  data);
      end
      int'(OP_WRITE): begin
        if (written_list.size() != 0 && $urandom_range(0, 1))
          addr = written_list[$urandom_range(0, written_list.size() - 1)];
        else
          addr = $urandom_range(0, WORD_DEPTH - 1);
        send_write(addr / WORDS_PER_BLOCK, addr % WORDS_PER_BLOCK, data);
      end
      default: begin
        send_item(3'($urandom_range(int'(OP_WRITE) + 1, 7)), BLK_W'($urandom),
                  WIDX_W'($urandom), data);
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // sequence of the run
  // --------------------------------------------------------------------------
  initial begin
    int unsigned fill_items;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part: reserved blocks, block zero, the top block, repeated
    // claims and frees, word extremes and the unknown op codes
    send_item(OP_REQUEST, 9'd0, 2'd0, '0);        // block zero is never granted by name
    send_item(OP_ALLOC, 9'd0, 2'd0, '0);          // lowest free is block zero
    send_item(OP_ALLOC, 9'd511, 2'd3, '1);        // block field ignored, next free block
    send_item(OP_REQUEST, 9'd127, 2'd0, '0);      // reserved after reset
    send_item(OP_REQUEST, 9'd128, 2'd0, '0);
    send_item(OP_REQUEST, 9'd511, 2'd0, '0);      // top block free
    send_item(OP_REQUEST, 9'd511, 2'd0, '0);      // now taken
    send_item(OP_RELEASE, 9'd511, 2'd0, '0);
    send_item(OP_RELEASE, 9'd511, 2'd0, '0);      // already free, ignored
    send_item(OP_RELEASE, 9'd127, 2'd0, '0);      // reserved block can be freed
    send_item(OP_RELEASE, 9'd0, 2'd0, '0);
    send_item(OP_ALLOC, 9'd0, 2'd0, '0);          // block zero comes back first
    send_write(0, 0, '1);
    send_write(511, 3, '0);
    send_write(300, 2, 64'h8000_0000_0000_0001);  // free block, map not consulted
    send_write(256, 1, 64'h5555_5555_5555_5555);
    send_item(OP_READ, 9'd511, 2'd3, '1);
    send_item(OP_READ, 9'd0, 2'd0, '0);
    send_item(OP_READ, 9'd300, 2'd2, '0);
    send_write(0, 0, 64'hAAAA_AAAA_AAAA_AAAA);    // overwrite
    send_item(OP_READ, 9'd0, 2'd0, '0);
    for (int k = int'(OP_WRITE) + 1; k < (1 << $bits(op_i)); k++)
      send_item(3'(k), BLK_W'(k * 73), WIDX_W'(k), {2{$urandom}});
    wait_drained();

    for (int n = 0; n < 150; n++) random_item(MIX_BALANCED);
    wait_drained();

    // fill the store until allocate has been refused several times
    fill_items = 0;
    while (alloc_sb.refused_full < 6 && fill_items < 900) begin
      random_item(MIX_FILL);
      fill_items++;
    end
    wait_drained();

    for (int n = 0; n < 250; n++) random_item(MIX_DRAIN);

    // a stretch with no idling on either side
    quiet = 1'b1;
    for (int n = 0; n < 120; n++) random_item(MIX_BALANCED);
    quiet = 1'b0;

    while (items_sent < ITEM_GOAL) random_item(MIX_BALANCED);
    wait_drained();
    repeat (END_SETTLE) @(posedge clk_i);

    $display("ran %0d transfers in %0d cycles, %0d results checked, peak used count %0d",
             items_sent, cycle_count, alloc_sb.checked, alloc_sb.peak_used);
    $display("%0d allocations granted, %0d refused on a full store, %0d word reads compared",
             alloc_sb.granted, alloc_sb.refused_full, alloc_sb.reads_done);
    if (alloc_sb.errors == 0 && alloc_sb.pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ bitmap_block_allocator_core.f @@
design/bba_pkg.sv
design/bba_map_store.sv
design/bitmap_block_allocator_core.sv
bench/bitmap_block_allocator_core_tb.sv
